[design/thick_line_rasterizer_assert.svh]
// Assertion helpers for the line rasterizer. Clock and reset are taken from
// the scope of use (clk, rst).
`ifndef THICK_LINE_RASTERIZER_ASSERT_SVH
`define THICK_LINE_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tlr_pkg.sv]
package tlr_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int SCREEN_BITS        = 11;
  localparam int COLOR_BITS         = 8;
  localparam int THICK_BITS         = 10;
  localparam int HALF_BITS          = THICK_BITS - 1;
  localparam int OFF_BITS           = HALF_BITS + 1;
  localparam int PIXEL_BITS         = 11;
  localparam int CFG_INDEX_BITS     = 1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = SCREEN_BITS'(240);
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = SCREEN_BITS'(240);

  // register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // input mode bit
  localparam logic MODE_START = 1'b0;

  // which copy of the line is being walked
  typedef enum logic [2:0] {
    SIDE_CENTER = 3'b001,
    SIDE_MINUS  = 3'b010,
    SIDE_PLUS   = 3'b100
  } side_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] x;
    logic [PIXEL_BITS-1:0] y;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  last;
  } pixel_t;

endpackage

[design/thick_line_rasterizer.sv]
// Thick line rasterizer.
// Command channel (cmd_valid / cmd_stall): mode 0 is a start beat carrying two
// endpoints, a color and a thickness; it makes no pixel and aborts any line in
// progress. Mode 1 is a request beat; while a line is active each request
// makes exactly one pixel beat, otherwise it is swallowed without a result.
// Pixel channel (pix_valid / pix_stall): one beat per pixel, last marks the
// final pixel of the final copy. Center line first, then minus and plus
// copies at offsets 1 .. thickness/2 (shifted in y for x-major lines, in x
// otherwise); copies starting off screen are skipped.
// Config port: cfg_we with cfg_index / cfg_data sets screen width and height;
// write only while no line is active.
// Throughput: one command beat per cycle while cmd_stall is low. A Bresenham
// step is one add/compare level off the state registers; setting up the next
// copy is a short chain of limit compare, endpoint shift and distance / error
// setup. A request beat's pixel is registered in the output register, or in
// the skid entry behind it, which takes one more pixel beat while the sink
// stalls; cmd_stall is high exactly while it is full, and it drains on the
// first edge without pixel stall.
// Reset (rst, synchronous): idle, both screen registers back to 240, no
// pixel pending.
module thick_line_rasterizer #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tlr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tlr_pkg::SCREEN_BITS-1:0]       cfg_data,
  input  logic                                  cmd_valid,
  output logic                                  cmd_stall,
  input  logic                                  mode,
  input  logic [COORD_BITS-1:0]                 start_x,
  input  logic [COORD_BITS-1:0]                 start_y,
  input  logic [COORD_BITS-1:0]                 end_x,
  input  logic [COORD_BITS-1:0]                 end_y,
  input  logic [tlr_pkg::COLOR_BITS-1:0]        red,
  input  logic [tlr_pkg::COLOR_BITS-1:0]        green,
  input  logic [tlr_pkg::COLOR_BITS-1:0]        blue,
  input  logic [tlr_pkg::THICK_BITS-1:0]        thickness,
  output logic                                  pix_valid,
  input  logic                                  pix_stall,
  output logic [tlr_pkg::PIXEL_BITS-1:0]        pixel_x,
  output logic [tlr_pkg::PIXEL_BITS-1:0]        pixel_y,
  output logic [tlr_pkg::COLOR_BITS-1:0]        pixel_red,
  output logic [tlr_pkg::COLOR_BITS-1:0]        pixel_green,
  output logic [tlr_pkg::COLOR_BITS-1:0]        pixel_blue,
  output logic                                  last
);

  // Cursor width: an endpoint plus the largest offset must fit.
  localparam int CW  = ((COORD_BITS > tlr_pkg::HALF_BITS) ? COORD_BITS
                                                           : tlr_pkg::HALF_BITS) + 1;
  localparam int EW  = CW + 2;           // error term, signed
  localparam int E2W = EW + 1;           // doubled error term
  localparam int SW  = COORD_BITS + 12;  // compare width for limit checks
  localparam logic [CW-1:0] C_ONE = CW'(1);

  typedef struct packed {
    logic [CW-1:0]        cx;
    logic [CW-1:0]        cy;
    logic [CW-1:0]        ex;
    logic [CW-1:0]        ey;
    logic [CW-1:0]        dx;
    logic [CW-1:0]        dy;
    logic signed [EW-1:0] err;
    logic                 nx;
    logic                 ny;
  } walk_t;

  // Bresenham setup for one walk.
  function automatic walk_t begin_walk(input logic [CW-1:0] x0, input logic [CW-1:0] y0,
                                       input logic [CW-1:0] x1, input logic [CW-1:0] y1);
    walk_t w;
    w.dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    w.dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    w.nx  = !(x0 < x1);
    w.ny  = !(y0 < y1);
    w.err = $signed(EW'(w.dx)) - $signed(EW'(w.dy));
    w.cx  = x0;
    w.cy  = y0;
    w.ex  = x1;
    w.ey  = y1;
    return w;
  endfunction

  // Whether a copy at this side and offset is drawn.
  function automatic logic pass_ok(input tlr_pkg::side_t side,
                                   input logic [tlr_pkg::OFF_BITS-1:0] off,
                                   input logic [COORD_BITS-1:0] s0,
                                   input logic [tlr_pkg::HALF_BITS-1:0] hw,
                                   input logic [tlr_pkg::SCREEN_BITS-1:0] lim);
    logic range_ok;
    range_ok = SW'(off) <= SW'(hw);
    if (side == tlr_pkg::SIDE_MINUS) begin
      return range_ok && (SW'(off) <= SW'(s0));
    end else begin
      return range_ok && ((SW'(s0) + SW'(off)) < SW'(lim));
    end
  endfunction

  // config
  logic [tlr_pkg::SCREEN_BITS-1:0] screen_width, screen_height;

  // line state
  logic [CW-1:0]        cursor_x, cursor_y, pass_end_x, pass_end_y;
  logic [CW-1:0]        distance_x, distance_y;
  logic signed [EW-1:0] error_term;
  logic                 step_neg_x, step_neg_y;
  logic [COORD_BITS-1:0] line_sx, line_sy, line_ex, line_ey;
  logic [tlr_pkg::COLOR_BITS-1:0] color_r, color_g, color_b;
  logic [tlr_pkg::HALF_BITS-1:0]  half_width, offset_count;
  tlr_pkg::side_t       pass_side;
  logic                 horizontal_major;
  logic                 busy;

  // output register and skid entry
  tlr_pkg::pixel_t out_pix, skid_pix, new_pix;
  logic            skid_valid;

  logic accept, is_start, is_req, at_end;
  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !cmd_stall;
  assign is_start  = accept && (mode == tlr_pkg::MODE_START);
  assign is_req    = accept && (mode != tlr_pkg::MODE_START) && busy;
  assign at_end    = (cursor_x == pass_end_x) && (cursor_y == pass_end_y);

  // ---- Bresenham step on the current walk ----
  logic signed [E2W-1:0] e2, dxs, dys, err_sum;
  logic                  step_x, step_y;
  logic [CW-1:0]         cursor_x_step, cursor_y_step;

  always_comb begin
    e2      = $signed({error_term, 1'b0});
    dxs     = $signed(E2W'(distance_x));
    dys     = $signed(E2W'(distance_y));
    step_x  = e2 > -dys;
    step_y  = e2 < dxs;
    err_sum = E2W'(error_term);
    if (step_x) begin
      err_sum = err_sum - dys;
    end
    if (step_y) begin
      err_sum = err_sum + dxs;
    end
    cursor_x_step = cursor_x;
    if (step_x) begin
      cursor_x_step = step_neg_x ? cursor_x - C_ONE : cursor_x + C_ONE;
    end
    cursor_y_step = cursor_y;
    if (step_y) begin
      cursor_y_step = step_neg_y ? cursor_y - C_ONE : cursor_y + C_ONE;
    end
  end

  // ---- pick the next drawn copy ----
  // Skips are monotone in the offset: once a minus (or plus) copy falls off
  // the screen, every larger offset on that side does too. So at most two
  // candidates need a look: after a minus copy, the plus copy at the same
  // offset, then the minus copy one further out; after a plus copy (or the
  // center line, offset zero), the minus and then plus copy one further out.
  logic [COORD_BITS-1:0]            s0, s1;
  logic [tlr_pkg::SCREEN_BITS-1:0]  lim;
  logic [tlr_pkg::OFF_BITS-1:0]     off_cur, off_inc, try1_off, try2_off, sel_off;
  tlr_pkg::side_t                   try1_side, try2_side, sel_side;
  logic                             ok1, ok2, any_ok;
  logic [CW-1:0]                    a0, a1, ow, n0, n1, px0, py0, px1, py1;
  walk_t                            pass_walk, start_walk;

  always_comb begin
    s0      = horizontal_major ? line_sy : line_sx;
    s1      = horizontal_major ? line_ey : line_ex;
    lim     = horizontal_major ? screen_height : screen_width;
    off_cur = tlr_pkg::OFF_BITS'(offset_count);
    off_inc = off_cur + tlr_pkg::OFF_BITS'(1);
    if (pass_side == tlr_pkg::SIDE_MINUS) begin
      try1_side = tlr_pkg::SIDE_PLUS;
      try1_off  = off_cur;
      try2_side = tlr_pkg::SIDE_MINUS;
      try2_off  = off_inc;
    end else begin
      try1_side = tlr_pkg::SIDE_MINUS;
      try1_off  = off_inc;
      try2_side = tlr_pkg::SIDE_PLUS;
      try2_off  = off_inc;
    end
    ok1      = pass_ok(try1_side, try1_off, s0, half_width, lim);
    ok2      = pass_ok(try2_side, try2_off, s0, half_width, lim);
    any_ok   = ok1 || ok2;
    sel_side = ok1 ? try1_side : try2_side;
    sel_off  = ok1 ? try1_off : try2_off;

    // shifted endpoints; minus end clamps at zero, plus end is not clipped
    a0 = CW'(s0);
    a1 = CW'(s1);
    ow = CW'(sel_off);
    if (sel_side == tlr_pkg::SIDE_MINUS) begin
      n0 = a0 - ow;
      n1 = (a1 >= ow) ? a1 - ow : '0;
    end else begin
      n0 = a0 + ow;
      n1 = a1 + ow;
    end
    px0 = horizontal_major ? CW'(line_sx) : n0;
    py0 = horizontal_major ? n0 : CW'(line_sy);
    px1 = horizontal_major ? CW'(line_ex) : n1;
    py1 = horizontal_major ? n1 : CW'(line_ey);
    pass_walk  = begin_walk(px0, py0, px1, py1);
    start_walk = begin_walk(CW'(start_x), CW'(start_y), CW'(end_x), CW'(end_y));
  end

  // pixel made by a request beat: the cursor before it moves
  always_comb begin
    new_pix.x     = tlr_pkg::PIXEL_BITS'(cursor_x);
    new_pix.y     = tlr_pkg::PIXEL_BITS'(cursor_y);
    new_pix.red   = color_r;
    new_pix.green = color_g;
    new_pix.blue  = color_b;
    new_pix.last  = at_end && !any_ok;
  end

  // ---- state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= tlr_pkg::SCREEN_WIDTH_RESET;
      screen_height    <= tlr_pkg::SCREEN_HEIGHT_RESET;
      busy             <= 1'b0;
      pass_side        <= tlr_pkg::SIDE_CENTER;
      offset_count     <= '0;
      horizontal_major <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tlr_pkg::REG_SCREEN_WIDTH) begin
          screen_width <= cfg_data;
        end
        if (cfg_index == tlr_pkg::REG_SCREEN_HEIGHT) begin
          screen_height <= cfg_data;
        end
      end

      if (is_start) begin
        line_sx          <= start_x;
        line_sy          <= start_y;
        line_ex          <= end_x;
        line_ey          <= end_y;
        color_r          <= red;
        color_g          <= green;
        color_b          <= blue;
        half_width       <= thickness[tlr_pkg::THICK_BITS-1:1];
        offset_count     <= '0;
        pass_side        <= tlr_pkg::SIDE_CENTER;
        cursor_x         <= start_walk.cx;
        cursor_y         <= start_walk.cy;
        pass_end_x       <= start_walk.ex;
        pass_end_y       <= start_walk.ey;
        distance_x       <= start_walk.dx;
        distance_y       <= start_walk.dy;
        error_term       <= start_walk.err;
        step_neg_x       <= start_walk.nx;
        step_neg_y       <= start_walk.ny;
        horizontal_major <= start_walk.dx > start_walk.dy;
        busy             <= thickness != '0;
      end else if (is_req) begin
        if (at_end) begin
          if (any_ok) begin
            pass_side    <= sel_side;
            offset_count <= tlr_pkg::HALF_BITS'(sel_off);
            cursor_x     <= pass_walk.cx;
            cursor_y     <= pass_walk.cy;
            pass_end_x   <= pass_walk.ex;
            pass_end_y   <= pass_walk.ey;
            distance_x   <= pass_walk.dx;
            distance_y   <= pass_walk.dy;
            error_term   <= pass_walk.err;
            step_neg_x   <= pass_walk.nx;
            step_neg_y   <= pass_walk.ny;
          end else begin
            busy <= 1'b0;
          end
        end else begin
          cursor_x   <= cursor_x_step;
          cursor_y   <= cursor_y_step;
          error_term <= EW'(err_sum);
        end
      end
    end
  end

  // ---- output register with skid entry ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!pix_valid || !pix_stall) begin
      if (skid_valid) begin
        out_pix    <= skid_pix;
        pix_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_pix   <= new_pix;
        pix_valid <= is_req;
      end
    end else if (is_req) begin
      skid_pix   <= new_pix;
      skid_valid <= 1'b1;
    end
  end

  assign pixel_x     = out_pix.x;
  assign pixel_y     = out_pix.y;
  assign pixel_red   = out_pix.red;
  assign pixel_green = out_pix.green;
  assign pixel_blue  = out_pix.blue;
  assign last        = out_pix.last;

  // ---- checks ----
  logic on_center;
  assign on_center = (pass_side == tlr_pkg::SIDE_CENTER);

`include "thick_line_rasterizer_assert.svh"

  `TLR_ASSERT_NOW(a_skid_behind_out, skid_valid, pix_valid, "skid entry held with output empty")
  `TLR_ASSERT_NOW(a_center_offset, on_center, offset_count == '0, "center line with offset")
  `TLR_ASSERT_NEXT(a_done_goes_idle, is_req && at_end && !any_ok, !busy, "busy after last pixel")

endmodule

[dv/tlr_raster_sb_pkg.sv]
`timescale 1ns / 1ps
package tlr_raster_sb_pkg;
  import tlr_pkg::*;

  // Tracks the line state on every accepted command beat and queues the pixels
  // that the block owes; pixel beats are matched in order.
  class raster_scoreboard;
    int unsigned scr_w, scr_h;
    int cur_x, cur_y, err, dist_x, dist_y;
    bit x_down, y_down;
    int stop_x, stop_y;
    int ep_sx, ep_sy, ep_ex, ep_ey;
    logic [COLOR_BITS-1:0] col_r, col_g, col_b;
    int half_w, offset;
    side_t side;
    bit x_major, drawing;
    pixel_t pixels_due[$];
    int errors;

    function new();
      scr_w = SCREEN_WIDTH_RESET;
      scr_h = SCREEN_HEIGHT_RESET;
      col_r = '0;
      col_g = '0;
      col_b = '0;
      side = SIDE_CENTER;
      errors = 0;
    endfunction

    function void set_screen(logic [CFG_INDEX_BITS-1:0] idx, logic [SCREEN_BITS-1:0] val);
      if (idx == REG_SCREEN_WIDTH) begin
        scr_w = val;
      end else begin
        scr_h = val;
      end
    endfunction

    function void start_walk(int x0, int y0, int x1, int y1);
      dist_x = (x1 > x0) ? x1 - x0 : x0 - x1;
      dist_y = (y1 > y0) ? y1 - y0 : y0 - y1;
      x_down = !(x0 < x1);
      y_down = !(y0 < y1);
      err = dist_x - dist_y;
      cur_x = x0;
      cur_y = y0;
      stop_x = x1;
      stop_y = y1;
    endfunction

    // set up the copy at the current side and offset; 0 if it starts off screen
    function bit setup_copy();
      int x0, y0, x1, y1, s0, s1;
      int unsigned lim;
      bit ok;
      x0 = ep_sx;
      y0 = ep_sy;
      x1 = ep_ex;
      y1 = ep_ey;
      s0 = x_major ? y0 : x0;
      s1 = x_major ? y1 : x1;
      lim = x_major ? scr_h : scr_w;
      ok = 1'b1;
      if (side == SIDE_MINUS) begin
        if (s0 < offset) begin
          ok = 1'b0;
        end else begin
          s0 -= offset;
          s1 = (s1 >= offset) ? s1 - offset : 0;
        end
      end else begin
        if (int'(s0 + offset) >= lim) begin
          ok = 1'b0;
        end else begin
          s0 += offset;
          s1 += offset;
        end
      end
      if (x_major) begin
        y0 = s0;
        y1 = s1;
      end else begin
        x0 = s0;
        x1 = s1;
      end
      if (ok) start_walk(x0, y0, x1, y1);
      return ok;
    endfunction

    function bit advance_copy();
      bit found, exhausted;
      found = 1'b0;
      exhausted = 1'b0;
      while (!found && !exhausted) begin
        if (side == SIDE_MINUS) begin
          side = SIDE_PLUS;
        end else begin
          if (side == SIDE_CENTER) offset = 1;
          else offset++;
          side = SIDE_MINUS;
        end
        if (offset > half_w) exhausted = 1'b1;
        else found = setup_copy();
      end
      return found;
    endfunction

    function void note_command(logic m, logic [COORD_BITS_DEFAULT-1:0] sx, sy, ex, ey,
                               logic [COLOR_BITS-1:0] r, g, b,
                               logic [THICK_BITS-1:0] thick);
      pixel_t px;
      int e2;
      bit fin;
      if (m == MODE_START) begin
        ep_sx = sx;
        ep_sy = sy;
        ep_ex = ex;
        ep_ey = ey;
        col_r = r;
        col_g = g;
        col_b = b;
        half_w = thick / 2;
        offset = 0;
        side = SIDE_CENTER;
        start_walk(ep_sx, ep_sy, ep_ex, ep_ey);
        x_major = dist_x > dist_y;
        drawing = (thick != 0);
        return;
      end
      if (!drawing) return;
      px.x = PIXEL_BITS'(cur_x);
      px.y = PIXEL_BITS'(cur_y);
      px.red = col_r;
      px.green = col_g;
      px.blue = col_b;
      fin = 1'b0;
      if (cur_x == stop_x && cur_y == stop_y) begin
        if (!advance_copy()) begin
          fin = 1'b1;
          drawing = 1'b0;
        end
      end else begin
        e2 = 2 * err;
        if (e2 > -dist_y) begin
          err -= dist_y;
          cur_x += x_down ? -1 : 1;
        end
        if (e2 < dist_x) begin
          err += dist_x;
          cur_y += y_down ? -1 : 1;
        end
      end
      px.last = fin;
      pixels_due.push_back(px);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      errors++;
      if (errors <= 10)
        $display("pixel %s mismatch: expected %0d, got %0d", field, want, seen);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel beat at (%0d,%0d)", got.x, got.y);
        return;
      end
      want = pixels_due.pop_front();
      if (got.x !== want.x) report("x", want.x, got.x);
      if (got.y !== want.y) report("y", want.y, got.y);
      if (got.red !== want.red) report("red", want.red, got.red);
      if (got.green !== want.green) report("green", want.green, got.green);
      if (got.blue !== want.blue) report("blue", want.blue, got.blue);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction

    function void check_drained();
      if (pixels_due.size() != 0) begin
        errors++;
        if (errors <= 10)
          $display("%0d pixel beats never arrived", pixels_due.size());
      end
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import tlr_pkg::*;
  import tlr_raster_sb_pkg::*;

  localparam int CB = COORD_BITS_DEFAULT;
  // anything that is not a start beat asks for the next pixel
  localparam logic MODE_PIXEL = ~MODE_START;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [SCREEN_BITS-1:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic mode = 1'b0;
  logic [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [COLOR_BITS-1:0] red = '0, green = '0, blue = '0;
  logic [THICK_BITS-1:0] thickness = '0;
  logic pix_valid;
  logic pix_stall = 1'b0;
  logic [PIXEL_BITS-1:0] pixel_x, pixel_y;
  logic [COLOR_BITS-1:0] pixel_red, pixel_green, pixel_blue;
  logic last;

  raster_scoreboard sb = new();

  int line_beats = 0;   // start beats plus requests made while a line is live
  bit quiet_cmd = 1'b0; // per-line: command side runs back to back
  int hold_run = 0;
  int pick;

  always #5 clk = ~clk;

  thick_line_rasterizer uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .mode        (mode),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .thickness   (thickness),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .last        (last)
  );

  // Pixel-side backpressure: runs of stall / no stall, mostly short, with the
  // odd long stall and the odd long stretch where the sink never pushes back.
  always @(negedge clk) begin
    if (hold_run > 0) begin
      hold_run--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pix_stall <= 1'b0;
        hold_run = $urandom_range(0, 6);
      end else if (pick < 92) begin
        pix_stall <= 1'b1;
        hold_run = $urandom_range(0, 2);
      end else if (pick < 97) begin
        pix_stall <= 1'b1;
        hold_run = $urandom_range(3, 12);
      end else if (pick < 99) begin
        pix_stall <= 1'b0;
        hold_run = $urandom_range(50, 150);
      end else begin
        pix_stall <= 1'b1;
        hold_run = $urandom_range(20, 40);
      end
    end
  end

  // Every accepted pixel beat is matched against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall)
      sb.check_pixel(pixel_t'{pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, last});
  end

  // idle cycles ahead of a command beat
  function automatic int pick_gap();
    int r;
    if (quiet_cmd) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Drives one command beat from a falling edge and holds it until taken.
  // Valid only drops when a gap is inserted, never within the same step.
  task automatic send_cmd(input logic m, input logic [CB-1:0] sx, sy, ex, ey,
                          input logic [COLOR_BITS-1:0] r, g, b,
                          input logic [THICK_BITS-1:0] thick);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    start_x = sx;
    start_y = sy;
    end_x = ex;
    end_y = ey;
    red = r;
    green = g;
    blue = b;
    thickness = thick;
    cmd_valid = 1'b1;
    do @(posedge clk); while (cmd_stall);
    if (m == MODE_START || sb.drawing) line_beats++;
    sb.note_command(m, sx, sy, ex, ey, r, g, b, thick);
  endtask

  // request beat; the unused fields carry noise
  task automatic send_request();
    send_cmd(MODE_PIXEL, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
             COLOR_BITS'($urandom), COLOR_BITS'($urandom), COLOR_BITS'($urandom),
             THICK_BITS'($urandom));
  endtask

  // stop sending and wait until every owed pixel has come out
  task automatic drain_pixels(input int tail);
    @(negedge clk);
    cmd_valid = 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [SCREEN_BITS-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_screen(idx, val);
  endtask

  // Zero-thickness start kills any live line, then the screen is resized
  // once the pixel side has gone quiet.
  task automatic set_screen_size(input int unsigned w, input int unsigned h);
    send_cmd(MODE_START, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
             COLOR_BITS'($urandom), COLOR_BITS'($urandom), COLOR_BITS'($urandom), '0);
    drain_pixels(8);
    write_reg(REG_SCREEN_WIDTH, SCREEN_BITS'(w));
    write_reg(REG_SCREEN_HEIGHT, SCREEN_BITS'(h));
  endtask

  // screen extent used to place coordinates; odd register values fall back
  function automatic int usable(input int unsigned lim);
    return (lim == 0 || lim > 1024) ? 1024 : int'(lim);
  endfunction

  // a coordinate hugging either border, so copies get skipped or clamped
  function automatic int near_edge(input int lim);
    int v;
    if ($urandom_range(0, 1)) return $urandom_range(0, 3);
    v = lim - 1 - int'($urandom_range(0, 3));
    return (v < 0) ? 0 : v;
  endfunction

  function automatic int wiggle(input int c, input int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // One line command with its requests. Most lines are short and walked to the
  // end; some sit on the screen border; a few use the full field range (wide
  // coordinates, huge thickness) and are cut off by the next start.
  task automatic draw_random_line();
    int kind, lim_x, lim_y, x0, y0, x1, y1, thick, budget, n;
    kind = $urandom_range(0, 9);
    lim_x = usable(sb.scr_w);
    lim_y = usable(sb.scr_h);
    quiet_cmd = ($urandom_range(0, 4) == 0);
    budget = 1000;
    case (kind)
      8: begin
        x0 = $urandom_range(0, 1023);
        y0 = $urandom_range(0, 1023);
        x1 = $urandom_range(0, 1023);
        y1 = $urandom_range(0, 1023);
        thick = $urandom_range(0, 1023);
        budget = $urandom_range(1, 30);
      end
      6, 7: begin
        x0 = $urandom_range(0, 1) ? near_edge(lim_x) : $urandom_range(0, lim_x - 1);
        y0 = $urandom_range(0, 1) ? near_edge(lim_y) : $urandom_range(0, lim_y - 1);
        x1 = wiggle(x0, 6);
        y1 = wiggle(y0, 6);
        thick = $urandom_range(1, 14);
      end
      default: begin
        x0 = $urandom_range(0, lim_x - 1);
        y0 = $urandom_range(0, lim_y - 1);
        x1 = wiggle(x0, 6);
        y1 = wiggle(y0, 6);
        thick = $urandom_range(0, 8);
        if (kind == 9) budget = $urandom_range(1, 20);
      end
    endcase
    send_cmd(MODE_START, CB'(x0), CB'(y0), CB'(x1), CB'(y1),
             COLOR_BITS'($urandom), COLOR_BITS'($urandom), COLOR_BITS'($urandom),
             THICK_BITS'(thick));
    n = 0;
    while (sb.drawing && n < budget) begin
      send_request();
      n++;
      // sender holds off until the pixel side has caught up
      if ($urandom_range(0, 59) == 0) drain_pixels(0);
    end
    // now and then poke the block while it has nothing to draw
    if (!sb.drawing && $urandom_range(0, 5) == 0) send_request();
  endtask

  task automatic run_random(input int beats);
    int first;
    first = line_beats;
    while (line_beats - first < beats) draw_random_line();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed: default 240 x 240 screen ---
    // request with nothing to draw
    send_request();
    // zero thickness: start leaves the block idle
    send_cmd(MODE_START, 10'd5, 10'd5, 10'd9, 10'd7, 8'd1, 8'd2, 8'd3, 10'd0);
    send_request();
    // single-point line: one pixel, flagged last; the next request is dropped
    send_cmd(MODE_START, 10'd0, 10'd0, 10'd0, 10'd0, 8'd255, 8'd0, 8'd255, 10'd1);
    send_request();
    send_request();
    // steep line at the left border: minus copy end clamps to column 0
    send_cmd(MODE_START, 10'd1, 10'd0, 10'd0, 10'd2, 8'd0, 8'd255, 8'd0, 10'd3);
    while (sb.drawing) send_request();
    // full-range corners and thickness, aborted by fresh starts
    send_cmd(MODE_START, 10'd1023, 10'd0, 10'd0, 10'd1023, 8'd170, 8'd85, 8'd15, 10'd1023);
    repeat (3) send_request();
    send_cmd(MODE_START, 10'd0, 10'd1023, 10'd1023, 10'd0, 8'd85, 8'd170, 8'd240, 10'd1022);
    repeat (2) send_request();

    // --- random phases, each with its own screen size ---
    set_screen_size(1024, 1024);
    run_random(190);
    set_screen_size(1, 1);
    run_random(190);
    set_screen_size(20, 700);
    run_random(190);
    set_screen_size($urandom_range(1, 1024), $urandom_range(1, 1024));
    run_random(190);
    // register values outside the usual range are taken as written
    set_screen_size(0, 2047);
    run_random(190);
    set_screen_size(1024, 1);
    run_random(190);
    set_screen_size($urandom_range(1, 1024), $urandom_range(1, 1024));
    run_random(190);

    drain_pixels(10);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("thick_line_rasterizer verification clean");
    end else begin
      $display("thick_line_rasterizer verification failed");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #(80_000_000);
    $display("thick_line_rasterizer verification failed");
    $finish;
  end

endmodule
